// ===== hdl/bdq_pkg.sv =====
package bdq_pkg;

  localparam int unsigned BDQ_DEPTH = 16;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned POS_W     = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_POP_FRONT  = 3'd1,
    KIND_PUSH_BACK  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_SEARCH     = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] popped_value;
    logic [POS_W-1:0]          position;
  } rsp_t;

endpackage

// ===== hdl/bdq_ram.sv =====
module bdq_ram #(
  parameter int unsigned DEPTH = bdq_pkg::BDQ_DEPTH,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [bdq_pkg::VALUE_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [bdq_pkg::VALUE_W-1:0] rd_data_o
);
  import bdq_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/bdq_ctrl.sv =====
module bdq_ctrl #(
  parameter int unsigned DEPTH = bdq_pkg::BDQ_DEPTH,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bdq_pkg::req_t               in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bdq_pkg::rsp_t               out_rsp_o,
  output logic                        wr_en_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [bdq_pkg::VALUE_W-1:0] wr_data_o,
  output logic                        rd_en_o,
  output logic [AW-1:0]               rd_addr_o,
  input  logic [bdq_pkg::VALUE_W-1:0] rd_data_i
);
  import bdq_pkg::*;

  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DepthS  = SW'(DEPTH);
  localparam logic [OW-1:0] DepthO  = OW'(DEPTH);

  state_e                    state_q, state_d;
  logic [AW-1:0]             front_q, front_d;
  logic [OW-1:0]             occ_q, occ_d;
  logic [AW-1:0]             cnt_q, cnt_d;
  logic [AW-1:0]             addr_q, addr_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  rsp_t                      res_q, res_d;
  logic                      out_valid_q, out_valid_d;
  rsp_t                      out_q, out_d;

  logic          full, empty, accept;
  logic [AW-1:0] front_m1, front_p1, addr_p1, back_idx, tail_idx;
  logic [SW-1:0] back_sum, tail_sum;

  assign full   = (occ_q == DepthO);
  assign empty  = (occ_q == '0);
  assign accept = in_valid_i && in_ready_o;

  assign front_m1 = (front_q == '0) ? LastIdx : front_q - AW'(1);
  assign front_p1 = (front_q == LastIdx) ? '0 : front_q + AW'(1);
  assign addr_p1  = (addr_q == LastIdx) ? '0 : addr_q + AW'(1);

  assign back_sum = SW'(front_q) + SW'(occ_q);
  assign tail_sum = SW'(front_q) + SW'(occ_q) - SW'(1);
  assign back_idx = (back_sum >= DepthS) ? AW'(back_sum - DepthS) : AW'(back_sum);
  assign tail_idx = (tail_sum >= DepthS) ? AW'(tail_sum - DepthS) : AW'(tail_sum);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign wr_data_o   = VALUE_W'(in_req_i.value);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    occ_d       = occ_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    val_d       = val_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = front_m1;
    rd_en_o     = 1'b0;
    rd_addr_o   = front_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d              = in_req_i.value;
          res_d.status       = STATUS_OK;
          res_d.popped_value = '0;
          res_d.position     = '0;
          state_d            = ST_EMIT;
          case (in_req_i.kind)
            KIND_PUSH_FRONT: begin
              if (full) begin
                res_d.status = STATUS_FULL;
              end else begin
                wr_en_o   = 1'b1;
                wr_addr_o = front_m1;
                front_d   = front_m1;
                occ_d     = occ_q + OW'(1);
              end
            end
            KIND_PUSH_BACK: begin
              if (full) begin
                res_d.status = STATUS_FULL;
              end else begin
                wr_en_o   = 1'b1;
                wr_addr_o = back_idx;
                occ_d     = occ_q + OW'(1);
              end
            end
            KIND_POP_FRONT: begin
              if (empty) begin
                res_d.status = STATUS_EMPTY;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = front_q;
                front_d   = front_p1;
                occ_d     = occ_q - OW'(1);
                state_d   = ST_POP;
              end
            end
            KIND_POP_BACK: begin
              if (empty) begin
                res_d.status = STATUS_EMPTY;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = tail_idx;
                occ_d     = occ_q - OW'(1);
                state_d   = ST_POP;
              end
            end
            KIND_SEARCH: begin
              if (empty) begin
                res_d.status = STATUS_EMPTY;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = front_q;
                cnt_d     = '0;
                addr_d    = front_p1;
                state_d   = ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        res_d.popped_value = rd_data_i;
        state_d            = ST_EMIT;
      end
      ST_SEARCH: begin
        rd_en_o   = 1'b1;
        rd_addr_o = addr_q;
        addr_d    = addr_p1;
        if (rd_data_i == VALUE_W'(val_q)) begin
          res_d.position = POS_W'(cnt_q);
          state_d        = ST_EMIT;
        end else if (OW'(cnt_q) + OW'(1) == occ_q) begin
          res_d.status = STATUS_NOT_FOUND;
          state_d      = ST_EMIT;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    addr_q <= addr_d;
    val_q  <= val_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule

// ===== hdl/bounded_deque_with_search_core.sv =====
// Double-ended queue of up to DEPTH signed 32-bit values kept in a ring in a
// single-port-read synchronous memory. Each request pushes or pops at either
// end or searches for a value; every request yields exactly one response with
// a status, the popped value and the match position from the front. One
// request is in flight at a time, and a search is paced by the memory's one
// read port, which scans the stored entries one per cycle. A response held
// in the output register does not block the next request until that
// request's own response is ready.
module bounded_deque_with_search_core #(
  parameter int unsigned DEPTH = bdq_pkg::BDQ_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bdq_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bdq_pkg::rsp_t out_rsp_o
);
  import bdq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [VALUE_W-1:0] wr_data, rd_data;

  bdq_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  bdq_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

endmodule
